[design/kts_pkg.sv]
// Shared types and constants for the keyed table search, insert and delete unit.
package kts_pkg;

  localparam int TABLE_DEPTH_DEF = 128;
  localparam int KEY_W = 32;
  localparam int VAL_W = 64;
  localparam int POS_W = 8;

  typedef enum logic [1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_EXISTS  = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic             cmp;
    logic             load;
    logic             shift;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage

[design/kts_if.sv]
// Valid/ready channel interfaces for requests and results.
interface kts_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       op;
  logic signed [kts_pkg::KEY_W-1:0] key;
  logic [kts_pkg::VAL_W-1:0]        value;

  modport source (output valid, op, key, value, input ready);
  modport sink (input valid, op, key, value, output ready);
endinterface

interface kts_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [kts_pkg::POS_W-1:0] position;
  logic [kts_pkg::VAL_W-1:0] found_value;
  logic [kts_pkg::POS_W-1:0] entry_total;

  modport source (output valid, status, position, found_value, entry_total, input ready);
  modport sink (input valid, status, position, found_value, entry_total, output ready);
endinterface

[design/keyed_table_search_insert_delete_unit.sv]
// Top level of the keyed table search, insert and delete unit.
//
// Requests arrive on in_ch (op, key, value) and each gives exactly one
// result on out_ch (status, position, found_value, entry_total). The table
// is a row of cells, one per entry, that all compare their key with the
// request key in the cycle of the transfer and register the match. Once
// the output register is free, the first match is selected, the result is
// written to the output register, and an insert loads the cell at the count
// while a delete makes the matching cell and every later cell take its upper
// neighbor's entry.
// A new request is not accepted before the last one has finished; in_ch.ready
// is high while no request is being worked on. A finished result waits in
// the output register while the next request is accepted and compared; that
// request completes only once the waiting result has been taken, so a
// stalled receiver holds off the input after one request.
// Synchronous reset empties the table by clearing the count and drops any
// pending result; entry storage itself is not cleared.
module keyed_table_search_insert_delete_unit #(
  parameter int TABLE_DEPTH = kts_pkg::TABLE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  kts_in_if.sink    in_ch,
  kts_out_if.source out_ch
);
  import kts_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  op_t              op_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;

  logic             out_valid_r;
  status_t          status_r, status_nxt;
  logic [POS_W-1:0] pos_r;
  logic [VAL_W-1:0] fval_r, fval_nxt;
  logic [POS_W-1:0] total_r;
  logic [CW-1:0]    pos_nxt;
  logic [CW+POS_W-1:0] pos_ext, total_ext;

  logic             accept, fire, do_insert, do_delete;
  logic [KEY_W-1:0] bcast_key;

  logic [TABLE_DEPTH-1:0]             match_vec, ge_mask;
  logic [TABLE_DEPTH-1:0][KEY_W-1:0] keys;
  logic [TABLE_DEPTH-1:0][VAL_W-1:0] vals;
  logic             hit;
  logic [IW-1:0]    hit_idx;
  logic [VAL_W-1:0] sel_val;

  assign accept    = in_ch.valid && in_ch.ready;
  assign fire      = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);
  assign bcast_key = (state_r == S_IDLE) ? in_ch.key : key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op_t'(in_ch.op);
      key_r <= in_ch.key;
      val_r <= in_ch.value;
    end
  end

  always_comb begin
    status_nxt = ST_MISSING;
    pos_nxt    = count_r;
    fval_nxt   = '0;
    count_nxt  = count_r;
    do_insert  = 1'b0;
    do_delete  = 1'b0;
    case (op_r)
      OP_SEARCH: begin
        if (hit) begin
          status_nxt = ST_OK;
          pos_nxt    = CW'(hit_idx);
          fval_nxt   = sel_val;
        end
      end
      OP_INSERT: begin
        if (hit) begin
          status_nxt = ST_EXISTS;
          pos_nxt    = CW'(hit_idx);
        end else if (count_r == CW'(TABLE_DEPTH)) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_OK;
          do_insert  = fire;
          count_nxt  = count_r + CW'(1);
        end
      end
      OP_DELETE: begin
        if (hit) begin
          status_nxt = ST_OK;
          pos_nxt    = CW'(hit_idx);
          do_delete  = fire;
          count_nxt  = count_r - CW'(1);
        end
      end
      default: begin
        status_nxt = ST_MISSING;
      end
    endcase
  end

  assign pos_ext   = {{POS_W{1'b0}}, pos_nxt};
  assign total_ext = {{POS_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r <= status_nxt;
      pos_r    <= pos_ext[POS_W-1:0];
      fval_r   <= fval_nxt;
      total_r  <= total_ext[POS_W-1:0];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.position    = pos_r;
  assign out_ch.found_value = fval_r;
  assign out_ch.entry_total = total_r;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    cell_ctl_t        ctl;
    logic [KEY_W-1:0] nb_key;
    logic [VAL_W-1:0] nb_val;

    assign ctl.cmp   = accept;
    assign ctl.load  = do_insert && (count_r == CW'(i));
    assign ctl.shift = do_delete && ge_mask[i];
    assign ctl.key   = bcast_key;
    assign ctl.value = val_r;

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign nb_key = keys[i];
      assign nb_val = vals[i];
    end else begin : g_mid
      assign nb_key = keys[i+1];
      assign nb_val = vals[i+1];
    end

    kts_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .occ     (CW'(i) < count_r),
      .nb_key  (nb_key),
      .nb_val  (nb_val),
      .key_q   (keys[i]),
      .val_q   (vals[i]),
      .match_q (match_vec[i])
    );
  end

  kts_pick #(.DEPTH(TABLE_DEPTH)) u_pick (
    .clk       (clk),
    .rst_n     (rst_n),
    .match_vec (match_vec),
    .vals      (vals),
    .hit       (hit),
    .hit_idx   (hit_idx),
    .sel_val   (sel_val),
    .ge_mask   (ge_mask)
  );

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC) && !in_ch.ready)
    else $error("transfer did not start execution");
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_insert |=> count_r == $past(count_r) + CW'(1))
    else $error("insert did not grow the count");
  a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_delete |=> count_r == $past(count_r) - CW'(1))
    else $error("delete did not shrink the count");

endmodule

[design/kts_cell.sv]
// One table cell: holds one entry, compares it with the broadcast key and shifts from its neighbor.
module kts_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  kts_pkg::cell_ctl_t        ctl,
  input  logic                      occ,
  input  logic [kts_pkg::KEY_W-1:0] nb_key,
  input  logic [kts_pkg::VAL_W-1:0] nb_val,
  output logic [kts_pkg::KEY_W-1:0] key_q,
  output logic [kts_pkg::VAL_W-1:0] val_q,
  output logic                      match_q
);
  import kts_pkg::*;

  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic             match_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_r <= ctl.key;
      val_r <= ctl.value;
    end else if (ctl.shift) begin
      key_r <= nb_key;
      val_r <= nb_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctl.cmp) begin
      match_r <= occ && (key_r == ctl.key);
    end
  end

  assign key_q   = key_r;
  assign val_q   = val_r;
  assign match_q = match_r;

endmodule

[design/kts_pick.sv]
// First-match selection over the cell row: index, value and the shift mask for a delete.
module kts_pick #(
  parameter int DEPTH = kts_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [DEPTH-1:0]                      match_vec,
  input  logic [DEPTH-1:0][kts_pkg::VAL_W-1:0]  vals,
  output logic                                  hit,
  output logic [$clog2(DEPTH)-1:0]              hit_idx,
  output logic [kts_pkg::VAL_W-1:0]             sel_val,
  output logic [DEPTH-1:0]                      ge_mask
);
  import kts_pkg::*;

  localparam int IW = $clog2(DEPTH);

  logic [DEPTH-1:0] first;

  assign first   = match_vec & (~match_vec + DEPTH'(1));
  assign hit     = |match_vec;
  assign ge_mask = hit ? ~(first - DEPTH'(1)) : '0;

  always_comb begin
    hit_idx = '0;
    sel_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first[i]) begin
        hit_idx = hit_idx | IW'(i);
        sel_val = sel_val | vals[i];
      end
    end
  end

  a_first_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(first))
    else $error("more than one first match");
  a_hit_mask: assert property (@(posedge clk) disable iff (!rst_n) hit == (first != '0))
    else $error("hit disagrees with first-match mask");
  a_mask_start: assert property (@(posedge clk) disable iff (!rst_n)
    hit |-> ((ge_mask & first) == first))
    else $error("shift mask does not cover the removed entry");

endmodule
